// File: src/lpwbs_pkg.sv
`timescale 1ns / 1ps

package lpwbs_pkg;

   // Item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 2'd3;

   // Reset timing: short and long phases at a 10 ns clock
   localparam int CLK_NS = 10;
   localparam int SHORT_NS = 250;
   localparam int LONG_NS = 1000;
   localparam logic [CSR_W-1:0] SHORT_CYCLES = CSR_W'(SHORT_NS / CLK_NS);
   localparam logic [CSR_W-1:0] LONG_CYCLES  = CSR_W'(LONG_NS / CLK_NS);

   localparam int TIMER_BITS_DEFAULT = 10;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic accepted;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

// File: src/led_pulse_width_bit_serializer.sv
`timescale 1ns / 1ps

// One-wire LED data serializer. A load request (op = load) takes a byte while the
// serializer is idle; the byte goes out LSB first, each bit as a high phase then
// a low phase whose lengths come from the four phase registers (a one bit uses the
// one_* pair, a zero bit the zero_* pair). Each tick request advances the waveform
// by one step and returns the pin level of that step. Every request yields exactly
// one response. A request is taken every cycle while the single response register is
// empty or being drained; its response is shown the next cycle. Phase length zero
// acts as one, and lengths above the timer range saturate to 2^TIMER_BITS - 1.
module led_pulse_width_bit_serializer import lpwbs_pkg::*; #(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int LEN_W = (TIMER_BITS > CSR_W) ? TIMER_BITS : CSR_W;
   localparam logic [LEN_W-1:0] TimerMax = LEN_W'({TIMER_BITS{1'b1}});
   localparam logic [LEN_W-1:0] LenOne = LEN_W'(1);

   logic [CSR_W-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [7:0] shift_ff, shift_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic high_phase_ff, high_phase_in;
   logic [TIMER_BITS-1:0] phase_count_ff, phase_count_in;
   logic sending_ff, sending_in;
   logic final_ff, final_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic take;
   logic cur_bit;
   logic [CSR_W-1:0] raw_len;
   logic [LEN_W-1:0] len;
   logic [TIMER_BITS-1:0] count_inc;
   logic phase_end;

   // Accept while the response register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Write phase registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= SHORT_CYCLES;
         zero_low_ff <= LONG_CYCLES;
         one_high_ff <= LONG_CYCLES;
         one_low_ff <= SHORT_CYCLES;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata;
            CSR_ZERO_LOW: zero_low_ff <= csr_wdata;
            CSR_ONE_HIGH: one_high_ff <= csr_wdata;
            CSR_ONE_LOW: one_low_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick and clamp the length of the current phase
   always_comb begin
      cur_bit = shift_ff[bit_index_ff];
      if (cur_bit) begin
         raw_len = high_phase_ff ? one_high_ff : one_low_ff;
      end else begin
         raw_len = high_phase_ff ? zero_high_ff : zero_low_ff;
      end
      len = LEN_W'(raw_len);
      if (len == '0) begin
         len = LenOne;
      end
      if (len > TimerMax) begin
         len = TimerMax;
      end
      count_inc = phase_count_ff + TIMER_BITS'(1);
      phase_end = (count_inc == '0) || (LEN_W'(count_inc) >= len);
   end

   // Advance the serializer for one request
   always_comb begin
      shift_in = shift_ff;
      bit_index_in = bit_index_ff;
      high_phase_in = high_phase_ff;
      phase_count_in = phase_count_ff;
      sending_in = sending_ff;
      final_in = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.pin_level = sending_ff && high_phase_ff;
         rsp_data_in.accepted = 1'b0;
         rsp_data_in.frame_done = 1'b0;
         if (req_data.op == OP_LOAD) begin
            if (!sending_ff) begin
               shift_in = req_data.data_byte;
               bit_index_in = '0;
               high_phase_in = 1'b1;
               phase_count_in = '0;
               sending_in = 1'b1;
               final_in = req_data.last_byte;
               rsp_data_in.accepted = 1'b1;
            end
         end else if (sending_ff) begin
            phase_count_in = count_inc;
            if (phase_end) begin
               phase_count_in = '0;
               if (high_phase_ff) begin
                  high_phase_in = 1'b0;
               end else if (bit_index_ff == 3'd7) begin
                  sending_in = 1'b0;
                  rsp_data_in.frame_done = final_ff;
                  final_in = 1'b0;
                  bit_index_in = '0;
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  high_phase_in = 1'b1;
               end
            end
         end
         rsp_data_in.busy_res = sending_in;
      end
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         bit_index_ff <= '0;
         high_phase_ff <= 1'b0;
         phase_count_ff <= '0;
         sending_ff <= 1'b0;
         final_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         bit_index_ff <= bit_index_in;
         high_phase_ff <= high_phase_in;
         phase_count_ff <= phase_count_in;
         sending_ff <= sending_in;
         final_ff <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // A taken load always leaves the serializer busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.accepted |-> rsp_data_ff.busy_res && !rsp_data_ff.frame_done)
      else $error("accepted load without busy");

   // Frame done only when the serializer went idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_done |-> !rsp_data_ff.busy_res && !sending_ff)
      else $error("frame done while busy");

   // A request taken always produces a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("request lost");

   // Idle serializer keeps its bit position cleared
   assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> bit_index_ff == 3'd0 && !high_phase_ff)
      else $error("idle state not clean");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lpwbs_pkg::*;

   localparam int unsigned TIMER_MAX = (1 << TIMER_BITS_DEFAULT) - 1;
   localparam logic [CSR_W-1:0] RESET_SHORT = 10'd25;
   localparam logic [CSR_W-1:0] RESET_LONG = 10'd100;
   localparam logic [CSR_W-1:0] LEN_MAX = 10'd1023;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_AT = 60;
   localparam int HOLD_LEN = 300;
   localparam int RESET_TICKS = 160;
   localparam int LONG_TICKS = 20;
   localparam int RANDOM_REQS = 180;
   localparam int SETTING_REQS = 60;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   led_pulse_width_bit_serializer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted phase timing and serializer state
   logic [CSR_W-1:0] phase_cfg [4] = '{RESET_SHORT, RESET_LONG, RESET_LONG, RESET_SHORT};
   logic [7:0] shift_q = '0;
   logic [2:0] bit_idx = '0;
   logic high_ph = 1'b0;
   logic [TIMER_BITS_DEFAULT-1:0] phase_cnt = '0;
   logic sending_q = 1'b0;
   logic final_q = 1'b0;

   req_type pend_q [$];
   rsp_type expect_q [$];
   logic req_fire = 1'b0;
   int unsigned gen_left = 0;
   int live_items = 0;
   int err_cnt = 0;
   int rsp_seen = 0;
   int loads_taken = 0;
   int loads_refused = 0;
   int frames_done = 0;
   int wave_ticks = 0;
   int idle_ticks = 0;
   int timing_sets = 0;
   int cycle_cnt = 0;

   // Effective length of one phase: zero acts as one, saturate to the timer range
   function automatic int unsigned phase_cycles(logic bit_val, logic high);
      logic [CSR_W-1:0] raw;
      int unsigned len;
      if (bit_val) raw = high ? phase_cfg[CSR_ONE_HIGH] : phase_cfg[CSR_ONE_LOW];
      else raw = high ? phase_cfg[CSR_ZERO_HIGH] : phase_cfg[CSR_ZERO_LOW];
      len = (raw == '0) ? 1 : raw;
      if (len > TIMER_MAX) len = TIMER_MAX;
      return len;
   endfunction

   function automatic int unsigned byte_ticks(logic [7:0] b);
      int unsigned n = 0;
      for (int i = 0; i < 8; i++) n += phase_cycles(b[i], 1'b1) + phase_cycles(b[i], 1'b0);
      return n;
   endfunction

   // Advance the predicted waveform by one request and return its response
   function automatic rsp_type led_wave_step(req_type r);
      rsp_type o;
      int unsigned len;
      o = '0;
      o.pin_level = sending_q && high_ph;
      if (r.op == OP_LOAD) begin
         if (!sending_q) begin
            shift_q = r.data_byte;
            bit_idx = '0;
            high_ph = 1'b1;
            phase_cnt = '0;
            sending_q = 1'b1;
            final_q = r.last_byte;
            o.accepted = 1'b1;
         end
      end else if (sending_q) begin
         len = phase_cycles(shift_q[bit_idx], high_ph);
         phase_cnt = phase_cnt + 1'b1;
         if (phase_cnt == '0 || phase_cnt >= len) begin
            phase_cnt = '0;
            if (high_ph) begin
               high_ph = 1'b0;
            end else if (bit_idx == 3'd7) begin
               sending_q = 1'b0;
               o.frame_done = final_q;
               final_q = 1'b0;
               bit_idx = '0;
            end else begin
               bit_idx = bit_idx + 1'b1;
               high_ph = 1'b1;
            end
         end
      end
      o.busy_res = sending_q;
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      err_cnt++;
      if (err_cnt <= 30) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Queue a request and track how far the current byte has to go
   task automatic queue_request(logic op, logic [7:0] data, logic last);
      req_type r;
      r.op = op;
      r.data_byte = data;
      r.last_byte = last;
      if (op == OP_LOAD && gen_left == 0) begin
         gen_left = byte_ticks(data);
         live_items++;
      end else if (op == OP_TICK && gen_left > 0) begin
         gen_left--;
         live_items++;
      end
      pend_q.push_back(r);
   endtask

   task automatic finish_byte();
      while (gen_left > 0)
         queue_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain_all();
      while (pend_q.size() != 0 || req_valid || expect_q.size() != 0) @(posedge clock);
   endtask

   // Tick an unfinished byte through to idle, one request at a time
   task automatic settle_byte();
      gen_left = 0;
      drain_all();
      while (sending_q) begin
         queue_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         drain_all();
      end
   endtask

   // Write all four phase lengths; only called with nothing in flight
   task automatic load_timing(logic [CSR_W-1:0] zh, logic [CSR_W-1:0] zl,
                              logic [CSR_W-1:0] oh, logic [CSR_W-1:0] ol);
      logic [CSR_W-1:0] vals [4];
      logic [CSR_IDX_W-1:0] idx [4];
      vals = '{zh, zl, oh, ol};
      idx = '{CSR_ZERO_HIGH, CSR_ZERO_LOW, CSR_ONE_HIGH, CSR_ONE_LOW};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         phase_cfg[idx[i]] = vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      timing_sets++;
   endtask

   // Mostly short phases so that many bytes go out, with zero and longer ones mixed in
   function automatic logic [CSR_W-1:0] rand_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 70) return CSR_W'($urandom_range(1, 4));
      if (r < 95) return CSR_W'($urandom_range(5, 16));
      return CSR_W'($urandom_range(17, 60));
   endfunction

   // Sender: offer requests in bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin : drive_req
      logic hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         hold = req_valid && !req_fire;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               req_data <= pend_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, with one long hold-off
   rx_mode_type rx_mode = RX_OPEN;
   int rx_run_left = 0;
   int rx_cycle = 0;
   int hold_left = 0;
   always @(negedge clock) begin : drive_rsp_ready
      logic nr;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == HOLD_AT) hold_left = HOLD_LEN;
         if (rx_run_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_run_left = $urandom_range(50, 400);
         end
         rx_run_left--;
         if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN: nr = 1'b1;
               RX_COIN: nr = 1'($urandom_range(0, 1));
               RX_EVERY_THIRD: nr = (rx_cycle % 3) != 0;
               default: nr = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= nr;
      end
   end

   // Monitor: check responses against the oldest expectation, predict on each request
   always @(posedge clock) begin : watch
      rsp_type want;
      logic was_busy;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expect_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with none expected", rsp_seen));
            end else begin
               want = expect_q.pop_front();
               if (rsp_data.pin_level !== want.pin_level)
                  report_mismatch($sformatf("response %0d pin_level %b, expected %b",
                                            rsp_seen, rsp_data.pin_level, want.pin_level));
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch($sformatf("response %0d accepted %b, expected %b",
                                            rsp_seen, rsp_data.accepted, want.accepted));
               if (rsp_data.busy_res !== want.busy_res)
                  report_mismatch($sformatf("response %0d busy_res %b, expected %b",
                                            rsp_seen, rsp_data.busy_res, want.busy_res));
               if (rsp_data.frame_done !== want.frame_done)
                  report_mismatch($sformatf("response %0d frame_done %b, expected %b",
                                            rsp_seen, rsp_data.frame_done, want.frame_done));
            end
         end
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            was_busy = sending_q;
            want = led_wave_step(req_data);
            expect_q.push_back(want);
            if (req_data.op == OP_LOAD) begin
               if (want.accepted) loads_taken++;
               else loads_refused++;
            end else if (was_busy) begin
               wave_ticks++;
            end else begin
               idle_ticks++;
            end
            if (want.frame_done) frames_done++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_cnt, expect_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int random_goal;
      int setting_goal;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: idle tick, a byte with a refused load behind it, then run
      // through a whole one bit and into the low phase of a zero bit
      queue_request(OP_TICK, 8'h00, 1'b0);
      queue_request(OP_LOAD, 8'h01, 1'b1);
      queue_request(OP_LOAD, 8'h00, 1'b0);
      repeat (RESET_TICKS) queue_request(OP_TICK, 8'hFF, 1'b0);
      drain_all();

      // Longest phases mid-byte: the count keeps running without ending the phase
      load_timing(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
      repeat (LONG_TICKS) queue_request(OP_TICK, 8'h5A, 1'b1);
      drain_all();

      // Zero-length phases behave as length one; a count already past the end
      // closes the phase at once
      load_timing('0, '0, '0, '0);
      settle_byte();
      queue_request(OP_LOAD, 8'h00, 1'b1);
      queue_request(OP_LOAD, 8'hFF, 1'b1);
      finish_byte();
      queue_request(OP_TICK, 8'h00, 1'b1);
      queue_request(OP_LOAD, 8'hFF, 1'b1);
      finish_byte();
      drain_all();

      // Random: mostly whole bytes with random content, some noise and refused loads
      random_goal = live_items + RANDOM_REQS;
      while (live_items < random_goal) begin
         load_timing(rand_len(), rand_len(), rand_len(), rand_len());
         setting_goal = live_items + SETTING_REQS;
         while (live_items < setting_goal) begin
            if ($urandom_range(0, 99) < 80) begin
               if (gen_left == 0)
                  queue_request(OP_LOAD, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
               while (gen_left > 0) begin
                  if ($urandom_range(0, 24) == 0)
                     queue_request(OP_LOAD, 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)));
                  queue_request(OP_TICK, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
               end
            end else begin
               queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
         end
         finish_byte();
         drain_all();
      end

      repeat (20) @(posedge clock);
      if (expect_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expect_q.size()));
      $display("Sent %0d bytes (%0d loads refused while busy), %0d frames closed,",
               loads_taken, loads_refused, frames_done);
      $display("%0d waveform ticks and %0d idle ticks over %0d timing settings, %0d checked",
               wave_ticks, idle_ticks, timing_sets, rsp_seen);
      if (err_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
src/lpwbs_pkg.sv
src/led_pulse_width_bit_serializer.sv
sim/testbench.sv
